@@ src/kb64_pkg.sv @@
`default_nettype none

package kb64_pkg;

    localparam int ALPHABET_SIZE = 64;
    localparam int ALPHA_AW      = 6;

    // Item actions.
    localparam logic [1:0] ACT_ALPHA   = 2'd0;
    localparam logic [1:0] ACT_REVERSE = 2'd1;
    localparam logic [1:0] ACT_DATA    = 2'd2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_PAD       = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_RESET = 8'd61;

    // One group handed from the assembler to the emitter.
    typedef struct packed {
        logic        is_enc;
        logic [23:0] bits;
        logic [2:0]  nsym;   // symbols looked up in the alphabet (encode)
        logic [2:0]  nres;   // words to emit, 1 to 4
        logic        last;
        logic        err;
    } t_job;

endpackage

`default_nettype wire

@@ src/kb64_ram.sv @@
`default_nettype none

module kb64_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/kb64_group.sv @@
`default_nettype none

module kb64_group (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_dir,
    input  wire logic [7:0]       i_pad,
    input  wire logic             i_clear,
    input  wire logic             i_load,
    input  wire logic [7:0]       i_data,
    input  wire logic             i_last,
    input  wire logic             i_in_range,
    input  wire logic [5:0]       i_rev_data,
    input  wire logic             i_job_ready,
    output logic                  o_job_valid,
    output kb64_pkg::t_job        o_job,
    output logic                  o_hold,
    output logic                  o_busy
);

    logic        r_b_valid, n_b_valid;
    logic [7:0]  r_b_data;
    logic        r_b_last;
    logic        r_b_in_range;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_gc, n_gc;
    logic [1:0]  r_sc, n_sc;

    logic [1:0]  eff_gc, enc_gc1;
    logic [23:0] eff_bits, enc_bits;
    logic        enc_job;

    logic        is_pad, full, dec_job, dec_err;
    logic [5:0]  v;
    logic [23:0] dec_bits, bits_after;
    logic [1:0]  gc_after, sc1;

    logic        makes_job, adv, fire;
    kb64_pkg::t_job job;

    // Encode: pack the byte into the next slot of the group.
    always_comb begin
        eff_gc   = (r_gc == 2'd3) ? 2'd0 : r_gc;
        eff_bits = (r_gc == 2'd3) ? 24'd0 : r_bits;
        unique case (eff_gc)
            2'd0:    enc_bits = eff_bits | {r_b_data, 16'd0};
            2'd1:    enc_bits = eff_bits | {8'd0, r_b_data, 8'd0};
            default: enc_bits = eff_bits | {16'd0, r_b_data};
        endcase
        enc_gc1 = eff_gc + 2'd1;
        enc_job = (enc_gc1 == 2'd3) || r_b_last;
    end

    // Decode: place the sextet from the reverse table into the group.
    always_comb begin
        is_pad = (r_b_data == i_pad);
        v      = r_b_in_range ? i_rev_data : 6'd0;
        unique case (r_gc)
            2'd0: dec_bits = r_bits | {v, 18'd0};
            2'd1: dec_bits = r_bits | {6'd0, v, 12'd0};
            2'd2: dec_bits = r_bits | {12'd0, v, 6'd0};
            2'd3: dec_bits = r_bits | {18'd0, v};
        endcase
        full       = !is_pad && (r_gc == 2'd3);
        gc_after   = is_pad ? r_gc : (full ? 2'd0 : r_gc + 2'd1);
        bits_after = is_pad ? r_bits : (full ? 24'd0 : dec_bits);
        sc1        = r_sc + 2'd1;
        dec_err    = (sc1 != 2'd0) || (gc_after == 2'd1);
        dec_job    = full || r_b_last;
    end

    always_comb begin
        job = '0;
        if (i_dir == kb64_pkg::DIR_ENCODE) begin
            job.is_enc = 1'b1;
            job.bits   = enc_bits;
            job.nsym   = {1'b0, enc_gc1} + 3'd1;
            job.nres   = 3'd4;
            job.last   = r_b_last;
            job.err    = 1'b0;
        end else begin
            job.is_enc = 1'b0;
            job.nsym   = 3'd0;
            job.last   = r_b_last;
            job.err    = r_b_last && dec_err;
            if (full) begin
                job.bits = dec_bits;
                job.nres = 3'd3;
            end else if (gc_after >= 2'd2) begin
                job.bits = bits_after;
                job.nres = {1'b0, gc_after} - 3'd1;
            end else begin
                // Nothing left to emit: a single zero word carries the flags.
                job.bits = 24'd0;
                job.nres = 3'd1;
            end
        end
    end

    assign makes_job   = r_b_valid && ((i_dir == kb64_pkg::DIR_ENCODE) ? enc_job : dec_job);
    assign adv         = !makes_job || i_job_ready;
    assign fire        = r_b_valid && adv;
    assign o_job_valid = makes_job;
    assign o_job       = job;
    assign o_hold      = r_b_valid && !adv;
    assign o_busy      = r_b_valid;

    always_comb begin
        n_b_valid = adv ? i_load : r_b_valid;
        n_bits    = r_bits;
        n_gc      = r_gc;
        n_sc      = r_sc;
        if (i_clear) begin
            n_bits = 24'd0;
            n_gc   = 2'd0;
            n_sc   = 2'd0;
        end else if (fire) begin
            if (i_dir == kb64_pkg::DIR_ENCODE) begin
                if (enc_job) begin
                    n_bits = 24'd0;
                    n_gc   = 2'd0;
                    n_sc   = 2'd0;
                end else begin
                    n_bits = enc_bits;
                    n_gc   = enc_gc1;
                end
            end else begin
                if (r_b_last) begin
                    n_bits = 24'd0;
                    n_gc   = 2'd0;
                    n_sc   = 2'd0;
                end else begin
                    n_bits = bits_after;
                    n_gc   = gc_after;
                    n_sc   = sc1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_bits    <= 24'd0;
            r_gc      <= 2'd0;
            r_sc      <= 2'd0;
        end else begin
            r_b_valid <= n_b_valid;
            r_bits    <= n_bits;
            r_gc      <= n_gc;
            r_sc      <= n_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_load) begin
            r_b_data     <= i_data;
            r_b_last     <= i_last;
            r_b_in_range <= i_in_range;
        end
    end

endmodule

`default_nettype wire

@@ src/kb64_emit.sv @@
`default_nettype none

module kb64_emit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [7:0]                      i_pad,
    input  wire logic                            i_job_valid,
    input  wire kb64_pkg::t_job                  i_job,
    output logic                                 o_job_ready,
    output logic                                 o_busy,
    output logic                                 o_a_re,
    output logic [kb64_pkg::ALPHA_AW-1:0]        o_a_raddr,
    input  wire logic [7:0]                      i_a_rdata,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_out_last,
    output logic                                 o_length_error
);

    logic           r_j_valid, n_j_valid;
    kb64_pkg::t_job r_j, n_j;
    logic [1:0]     r_q, n_q;

    logic           r_e_valid, r_e_ram, r_e_last, r_e_err;
    logic [7:0]     r_e_byte;

    logic           r_o_valid, r_o_last, r_o_err;
    logic [7:0]     r_o_byte;

    logic           out_ready, e_adv, step, last_step;
    logic [5:0]     sextet;
    logic [7:0]     octet;

    assign out_ready = !r_o_valid || !i_stall;
    assign e_adv     = !r_e_valid || out_ready;
    assign step      = r_j_valid && e_adv;
    assign last_step = ({1'b0, r_q} == (r_j.nres - 3'd1));

    assign o_job_ready = !r_j_valid || (step && last_step);
    assign o_busy      = r_j_valid;

    // Sextet q of the group, most significant first.
    always_comb begin
        unique case (r_q)
            2'd0: sextet = r_j.bits[23:18];
            2'd1: sextet = r_j.bits[17:12];
            2'd2: sextet = r_j.bits[11:6];
            2'd3: sextet = r_j.bits[5:0];
        endcase
        unique case (r_q)
            2'd0:    octet = r_j.bits[23:16];
            2'd1:    octet = r_j.bits[15:8];
            2'd2:    octet = r_j.bits[7:0];
            default: octet = 8'd0;
        endcase
    end

    assign o_a_re    = step && r_j.is_enc && ({1'b0, r_q} < r_j.nsym);
    assign o_a_raddr = sextet;

    always_comb begin
        n_j_valid = r_j_valid;
        n_j       = r_j;
        n_q       = r_q;
        if (o_job_ready && i_job_valid) begin
            n_j_valid = 1'b1;
            n_j       = i_job;
            n_q       = 2'd0;
        end else if (step && last_step) begin
            n_j_valid = 1'b0;
        end else if (step) begin
            n_q = r_q + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
            r_q       <= 2'd0;
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_j_valid <= n_j_valid;
            r_q       <= n_q;
            if (e_adv) begin
                r_e_valid <= step;
            end
            if (out_ready) begin
                r_o_valid <= r_e_valid;
            end
        end
    end

    // The alphabet read data is registered in the RAM, so the word waits
    // one stage before it meets the read data.
    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        if (e_adv) begin
            r_e_ram  <= o_a_re;
            r_e_byte <= r_j.is_enc ? i_pad : octet;
            r_e_last <= r_j.last && last_step;
            r_e_err  <= r_j.err;
        end
        if (out_ready) begin
            r_o_byte <= r_e_ram ? i_a_rdata : r_e_byte;
            r_o_last <= r_e_last;
            r_o_err  <= r_e_err;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_out_last     = r_o_last;
    assign o_length_error = r_o_err;

endmodule

`default_nettype wire

@@ src/keyed_base64_codec.sv @@
// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  i_action, i_table_index, i_table_value,
//                                         i_data_in, i_data_last
// output    out        o_valid / i_stall  o_out_byte, o_out_last, o_length_error
// config    in         APB psel/penable   paddr 0 direction, paddr 4 pad symbol
//
// One input word is taken per cycle while o_stall is low; results leave at one
// word per cycle while i_stall is low, from a single emitter, which also owns
// the one alphabet read port. Encoding is therefore bound by the emitter, which
// sends four symbols per three bytes; decoding takes one symbol per cycle.
// Reset is synchronous; the tables keep their contents and need no clearing pass.
// An alphabet write is held off while a group is still waiting for lookups.
`default_nettype none

module keyed_base64_codec #(
    parameter int REVERSE_SIZE = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_table_index,
    input  wire logic [7:0]  i_table_value,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_data_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic             o_length_error
);

    localparam int RW = $clog2(REVERSE_SIZE);
    localparam logic [8:0] REV_LIMIT   = 9'(REVERSE_SIZE);
    localparam logic [8:0] ALPHA_LIMIT = 9'(kb64_pkg::ALPHABET_SIZE);

    logic       r_dir;
    logic [7:0] r_pad;
    logic       cfg_wr, clear;

    logic       accept, hold, alpha_block;
    logic       g_busy, e_busy;
    logic       a_we, r_we, r_re, load;
    logic       a_re;
    logic [kb64_pkg::ALPHA_AW-1:0] a_raddr;
    logic [7:0] a_rdata;
    logic [5:0] rev_rdata;
    logic       job_valid, job_ready;
    kb64_pkg::t_job job;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite;
    assign clear  = cfg_wr && (paddr[2] == kb64_pkg::REG_DIRECTION);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == kb64_pkg::REG_DIRECTION) ? {31'd0, r_dir} : {24'd0, r_pad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= kb64_pkg::DIR_ENCODE;
            r_pad <= kb64_pkg::PAD_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == kb64_pkg::REG_DIRECTION) begin
                r_dir <= pwdata[0];
            end else begin
                r_pad <= pwdata[7:0];
            end
        end
    end

    // A new alphabet entry must not overtake a group still to be looked up.
    assign alpha_block = (i_action == kb64_pkg::ACT_ALPHA) && (g_busy || e_busy);
    assign o_stall     = hold || alpha_block;
    assign accept      = i_valid && !o_stall;

    assign a_we = accept && (i_action == kb64_pkg::ACT_ALPHA)
                  && ({1'b0, i_table_index} < ALPHA_LIMIT);
    assign r_we = accept && (i_action == kb64_pkg::ACT_REVERSE)
                  && ({1'b0, i_table_index} < REV_LIMIT);
    assign load = accept && (i_action == kb64_pkg::ACT_DATA);
    assign r_re = load && (r_dir == kb64_pkg::DIR_DECODE);

    kb64_ram #(
        .WIDTH(8),
        .DEPTH(kb64_pkg::ALPHABET_SIZE)
    ) u_alpha (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_waddr(i_table_index[kb64_pkg::ALPHA_AW-1:0]),
        .i_wdata(i_table_value),
        .i_re   (a_re),
        .i_raddr(a_raddr),
        .o_rdata(a_rdata)
    );

    kb64_ram #(
        .WIDTH(6),
        .DEPTH(REVERSE_SIZE)
    ) u_reverse (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(i_table_index[RW-1:0]),
        .i_wdata(i_table_value[5:0]),
        .i_re   (r_re),
        .i_raddr(i_data_in[RW-1:0]),
        .o_rdata(rev_rdata)
    );

    kb64_group u_group (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dir      (r_dir),
        .i_pad      (r_pad),
        .i_clear    (clear),
        .i_load     (load),
        .i_data     (i_data_in),
        .i_last     (i_data_last),
        .i_in_range ({1'b0, i_data_in} < REV_LIMIT),
        .i_rev_data (rev_rdata),
        .i_job_ready(job_ready),
        .o_job_valid(job_valid),
        .o_job      (job),
        .o_hold     (hold),
        .o_busy     (g_busy)
    );

    kb64_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pad         (r_pad),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_ready   (job_ready),
        .o_busy        (e_busy),
        .o_a_re        (a_re),
        .o_a_raddr     (a_raddr),
        .i_a_rdata     (a_rdata),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_length_error(o_length_error)
    );

endmodule

`default_nettype wire
